[rtl/gbf_pkg.sv]
// ----------------------------------------------------------------------------
// gbf_pkg
// shared sizes, action codes and controller interface types for the garbled
// bloom filter engine
// ----------------------------------------------------------------------------
package gbf_pkg;

   localparam int unsigned SLOTS      = 1024;
   localparam int unsigned SHARE_BITS = 64;
   localparam int unsigned SLOT_BITS  = $clog2(SLOTS);
   localparam int unsigned ENTRY_BITS = SHARE_BITS + 1;

   // port field widths
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned WORD_W   = 64;

   typedef logic [ACTION_W-1:0] action_type;

   localparam action_type ACT_ADD   = 2'd0;
   localparam action_type ACT_QUERY = 2'd1;
   localparam action_type ACT_FILL  = 2'd2;

   typedef struct packed {
      logic capture;
      logic step;
      logic finish;
      logic clear_step;
      logic emit;
   } gbf_cmd_type;

   typedef struct packed {
      logic is_add;
      logic is_query;
      logic is_fill;
      logic last;
      logic rsp_block;
      logic clear_done;
   } gbf_sts_type;

endpackage

[rtl/gbf_ctrl.sv]
// ----------------------------------------------------------------------------
// gbf_ctrl
// sequencing state machine: store clearing, request capture, slot update and
// end-of-element write
// ----------------------------------------------------------------------------
module gbf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  gbf_pkg::gbf_sts_type sts,
   output gbf_pkg::gbf_cmd_type cmd
);
   import gbf_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_EXEC   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      needs_rsp;

   assign needs_rsp = sts.is_fill || (sts.is_query && sts.last);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!(needs_rsp && sts.rsp_block)) begin
               cmd.step = 1'b1;
               cmd.emit = needs_rsp;
               state_in = (sts.is_add && sts.last) ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_block) begin
               cmd.finish = 1'b1;
               cmd.emit   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.step, cmd.finish, cmd.clear_step}))
      else $error("more than one datapath command at once");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !sts.rsp_block)
      else $error("response emitted over a stalled response");

   a_capture_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> (state_ff == ST_EXEC))
      else $error("captured request not executed next");

   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> (state_ff == ST_IDLE))
      else $error("finish did not return to idle");

endmodule

[rtl/gbf_datapath.sv]
// ----------------------------------------------------------------------------
// gbf_datapath
// share store with occupancy bits, request registers, xor accumulator, held
// slot and response register
// ----------------------------------------------------------------------------
module gbf_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  gbf_pkg::gbf_cmd_type         cmd,
   output gbf_pkg::gbf_sts_type         sts,
   input  gbf_pkg::action_type          req_action,
   input  logic [gbf_pkg::INDEX_W-1:0]  req_slot_index,
   input  logic                         req_index_valid,
   input  logic [gbf_pkg::WORD_W-1:0]   req_random_share,
   input  logic [gbf_pkg::WORD_W-1:0]   req_element_tag,
   input  logic                         req_last_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic                         rsp_match
);
   import gbf_pkg::*;

   logic [ENTRY_BITS-1:0] mem [SLOTS];
   logic [ENTRY_BITS-1:0] rd_ff;

   action_type            action_ff;
   logic [INDEX_W-1:0]    slot_ff;
   logic                  ivalid_ff;
   logic [SHARE_BITS-1:0] share_ff;
   logic [SHARE_BITS-1:0] tag_ff;
   logic                  last_ff;

   logic [SHARE_BITS-1:0] acc_ff, acc_in;
   logic [SLOT_BITS-1:0]  held_ff, held_in;
   logic                  hv_ff, hv_in;
   logic [SLOT_BITS-1:0]  clr_cnt_ff;

   logic                  rsp_valid_ff, rsp_status_ff, rsp_match_ff;
   logic                  rsp_status_in, rsp_match_in;

   logic                  in_range, rd_occ;
   logic [SHARE_BITS-1:0] rd_share;
   logic [SLOT_BITS-1:0]  slot_addr;
   logic                  step_we, we;
   logic [SLOT_BITS-1:0]  waddr;
   logic [ENTRY_BITS-1:0] wdata;

   assign in_range  = (32'(slot_ff) < 32'(SLOTS));
   assign slot_addr = SLOT_BITS'(slot_ff);
   assign rd_occ    = rd_ff[SHARE_BITS];
   assign rd_share  = rd_ff[SHARE_BITS-1:0];

   // slot update for one index
   always_comb begin
      acc_in        = acc_ff;
      held_in       = held_ff;
      hv_in         = hv_ff;
      step_we       = 1'b0;
      rsp_status_in = 1'b0;
      rsp_match_in  = 1'b0;
      if (action_ff == ACT_FILL) begin
         step_we = in_range && !rd_occ;
      end else if (action_ff == ACT_ADD || action_ff == ACT_QUERY) begin
         if (ivalid_ff && in_range) begin
            if (action_ff == ACT_QUERY || rd_occ) begin
               acc_in = acc_ff ^ rd_share;
            end else if (!hv_ff) begin
               held_in = slot_addr;
               hv_in   = 1'b1;
            end else begin
               step_we = 1'b1;
               acc_in  = acc_ff ^ share_ff;
            end
         end
         if (action_ff == ACT_QUERY && last_ff) begin
            rsp_match_in = (acc_in == tag_ff);
            acc_in       = '0;
            held_in      = '0;
            hv_in        = 1'b0;
         end
      end
      if (cmd.finish) begin
         rsp_status_in = !hv_ff;
         rsp_match_in  = 1'b0;
      end
   end

   // single write port
   always_comb begin
      we    = 1'b0;
      waddr = slot_addr;
      wdata = {1'b1, share_ff};
      if (cmd.clear_step) begin
         we    = 1'b1;
         waddr = clr_cnt_ff;
         wdata = '0;
      end else if (cmd.step) begin
         we = step_we;
      end else if (cmd.finish) begin
         we    = hv_ff;
         waddr = held_ff;
         wdata = {1'b1, acc_ff ^ tag_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.capture) begin
         rd_ff <= mem[SLOT_BITS'(req_slot_index)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff <= req_action;
         slot_ff   <= req_slot_index;
         ivalid_ff <= req_index_valid;
         share_ff  <= req_random_share[SHARE_BITS-1:0];
         tag_ff    <= req_element_tag[SHARE_BITS-1:0];
         last_ff   <= req_last_index;
      end
      if (cmd.emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_match_ff  <= rsp_match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         held_ff      <= '0;
         hv_ff        <= 1'b0;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.step) begin
            acc_ff  <= acc_in;
            held_ff <= held_in;
            hv_ff   <= hv_in;
         end else if (cmd.finish) begin
            acc_ff  <= '0;
            held_ff <= '0;
            hv_ff   <= 1'b0;
         end
         if (cmd.clear_step) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.is_add     = (action_ff == ACT_ADD);
   assign sts.is_query   = (action_ff == ACT_QUERY);
   assign sts.is_fill    = (action_ff == ACT_FILL);
   assign sts.last       = last_ff;
   assign sts.rsp_block  = rsp_valid_ff && rsp_stall;
   assign sts.clear_done = (clr_cnt_ff == SLOT_BITS'(SLOTS - 1));

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_match  = rsp_match_ff;

endmodule

[rtl/garbled_bloom_filter_engine.sv]
// ----------------------------------------------------------------------------
// garbled_bloom_filter_engine
// garbled bloom filter store of share words with add, query and fill requests
// ----------------------------------------------------------------------------
// After reset the engine clears its 1024-entry share store one entry per
// cycle and takes no request until the clear is done. Each request then has
// its slot read from the single-port store at capture, and the slot and the
// xor accumulator are updated in the execute state. The last index of an add
// element passes a finish state, as the held slot is written through the
// same store write port. A response is given on the last index of an add or
// query element and on every fill; it waits in an output register. A request
// whose own response would overwrite one still stalled waits in its update
// or finish state, and the next request is held off until it completes.
module garbled_bloom_filter_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  gbf_pkg::action_type          req_action,
   input  logic [gbf_pkg::INDEX_W-1:0]  req_slot_index,
   input  logic                         req_index_valid,
   input  logic [gbf_pkg::WORD_W-1:0]   req_random_share,
   input  logic [gbf_pkg::WORD_W-1:0]   req_element_tag,
   input  logic                         req_last_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_status,
   output logic                         rsp_match
);
   import gbf_pkg::*;

   gbf_cmd_type cmd;
   gbf_sts_type sts;

   gbf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gbf_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_action       (req_action),
      .req_slot_index   (req_slot_index),
      .req_index_valid  (req_index_valid),
      .req_random_share (req_random_share),
      .req_element_tag  (req_element_tag),
      .req_last_index   (req_last_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_match        (rsp_match)
   );

endmodule
